@@ rtl/xsa_pkg.sv @@
package xsa_pkg;

    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int WORD_W   = 64;
    localparam int OFFSET_W = 5;
    localparam int KIND_W   = 2;
    localparam int MULT_W   = 32;

    // Secret words 0 .. HEADS-1 live in flops, so that a run of eight that wraps
    // past the end of the store never lands two lanes in one bank.
    localparam int HEADS = LANES - 1;

    localparam int SCRAMBLE_SHIFT = 47;

    localparam int IN_TDATA_W  = ((OFFSET_W + LANES * WORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = LANES * WORD_W;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef word_t [LANES-1:0]        lane_words_t;

    localparam kind_t KIND_LOAD_SECRET = 2'd0;
    localparam kind_t KIND_ACCUMULATE  = 2'd1;
    localparam kind_t KIND_SCRAMBLE    = 2'd2;
    localparam kind_t KIND_LOAD_ACC    = 2'd3;

    localparam logic [MULT_W-1:0] MULT_RESET = 32'h9E37_79B1;

    typedef struct packed {
        logic  load;
        kind_t load_kind;
        logic  mul_en;
        logic  commit;
        kind_t op;
    } lane_ctrl_t;

endpackage

@@ rtl/xsa_secret_bank.sv @@
module xsa_secret_bank #(
    parameter int ROWS = 3
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(ROWS)-1:0]   wr_addr,
    input  xsa_pkg::word_t            wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(ROWS)-1:0]   rd_addr,
    input  logic                      rd_bypass,
    input  xsa_pkg::word_t            bypass_data,
    output xsa_pkg::word_t            rd_data
);

    xsa_pkg::word_t mem [ROWS];
    xsa_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rd_bypass ? bypass_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/xsa_secret_store.sv @@
module xsa_secret_store #(
    parameter int SECRET_WORDS = 24
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic                           wr_en,
    input  logic [xsa_pkg::OFFSET_W-1:0]   offset,
    input  xsa_pkg::lane_words_t           words,
    output xsa_pkg::lane_words_t           secret
);

    localparam int PW   = $clog2(SECRET_WORDS + xsa_pkg::HEADS);
    localparam int ROWS = (SECRET_WORDS + xsa_pkg::LANES - 1) / xsa_pkg::LANES;
    localparam int RW   = $clog2(ROWS);

    localparam logic [PW-1:0] N_P     = PW'(SECRET_WORDS);
    localparam logic [PW-1:0] HEADS_P = PW'(xsa_pkg::HEADS);

    logic [PW-1:0]                offset_ext;
    logic [PW-1:0]                base;
    logic [PW-1:0]                lane_pos [xsa_pkg::LANES];
    logic [PW-1:0]                lane_key [xsa_pkg::LANES];
    logic [xsa_pkg::LANE_W-1:0]   rot_reg;
    xsa_pkg::word_t               head_reg [xsa_pkg::HEADS];
    xsa_pkg::word_t               bank_q [xsa_pkg::LANES];

    // The offset field is below twice the store depth, so one subtract wraps it.
    always_comb
    begin
        offset_ext = PW'(offset);
        base = (offset_ext >= N_P) ? (offset_ext - N_P) : offset_ext;
        for (int i = 0; i < xsa_pkg::LANES; i++)
        begin
            lane_pos[i] = base + PW'(i);
            lane_key[i] = (lane_pos[i] >= N_P) ? (lane_pos[i] - N_P) : lane_pos[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int h = 0; h < xsa_pkg::HEADS; h++)
            begin
                for (int i = 0; i < xsa_pkg::LANES; i++)
                begin
                    if (lane_key[i] == PW'(h))
                    begin
                        head_reg[h] <= words[i];
                    end
                end
            end
        end
        if (rd_en)
        begin
            rot_reg <= base[xsa_pkg::LANE_W-1:0];
        end
    end

    for (genvar b = 0; b < xsa_pkg::LANES; b++)
    begin : g_bank
        localparam int LO_IDX = (b < xsa_pkg::HEADS) ? b : 0;
        localparam int HI_RAW = (b + xsa_pkg::LANES - (SECRET_WORDS % xsa_pkg::LANES))
                                % xsa_pkg::LANES;
        localparam int HI_IDX = (HI_RAW < xsa_pkg::HEADS) ? HI_RAW : 0;

        logic [xsa_pkg::LANE_W-1:0] sel;
        logic [PW-1:0]              pos;
        logic [RW-1:0]              row;
        logic                       in_mem;
        xsa_pkg::word_t             head_val;

        // Lane that falls in this bank, and its unwrapped position.
        assign sel      = xsa_pkg::LANE_W'(b) - base[xsa_pkg::LANE_W-1:0];
        assign pos      = base + PW'(sel);
        assign row      = RW'(pos >> xsa_pkg::LANE_W);
        assign in_mem   = (pos >= HEADS_P) && (pos < N_P);
        assign head_val = (pos < HEADS_P) ? head_reg[LO_IDX] : head_reg[HI_IDX];

        xsa_secret_bank #(
            .ROWS(ROWS)
        ) u_bank (
            .clk         (clk),
            .wr_en       (wr_en && in_mem),
            .wr_addr     (row),
            .wr_data     (words[sel]),
            .rd_en       (rd_en),
            .rd_addr     (row),
            .rd_bypass   (!in_mem),
            .bypass_data (head_val),
            .rd_data     (bank_q[b])
        );
    end

    // Rotate bank outputs back into lane order.
    always_comb
    begin
        for (int i = 0; i < xsa_pkg::LANES; i++)
        begin
            secret[i] = bank_q[xsa_pkg::LANE_W'(rot_reg + xsa_pkg::LANE_W'(i))];
        end
    end

endmodule

@@ rtl/xsa_lane.sv @@
module xsa_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xsa_pkg::lane_ctrl_t           ctrl,
    input  xsa_pkg::word_t                word,
    input  xsa_pkg::word_t                nb_word,
    input  xsa_pkg::word_t                secret,
    input  logic [xsa_pkg::MULT_W-1:0]    mult,
    output xsa_pkg::word_t                acc
);

    xsa_pkg::word_t dk_c;
    xsa_pkg::word_t prod_c;
    xsa_pkg::word_t data_c;
    xsa_pkg::word_t mix_c;
    xsa_pkg::word_t acc_next;

    xsa_pkg::word_t prod_reg;
    xsa_pkg::word_t data_reg;
    logic [31:0]    phi_reg;
    xsa_pkg::word_t acc_reg;

    always_comb
    begin
        dk_c   = word ^ secret;
        prod_c = {32'b0, dk_c[31:0]} * {32'b0, dk_c[63:32]};
        case (ctrl.load_kind)
            xsa_pkg::KIND_LOAD_ACC: data_c = word;
            xsa_pkg::KIND_SCRAMBLE: data_c = secret;
            default:                data_c = nb_word;
        endcase
        mix_c = acc_reg ^ (acc_reg >> xsa_pkg::SCRAMBLE_SHIFT) ^ data_reg;
    end

    // Scramble reuses prod_reg for the low partial product.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_c;
            data_reg <= data_c;
        end
        else if (ctrl.mul_en)
        begin
            prod_reg <= {32'b0, mix_c[31:0]} * {32'b0, mult};
            phi_reg  <= mix_c[63:32] * mult;
        end
    end

    always_comb
    begin
        case (ctrl.op)
            xsa_pkg::KIND_ACCUMULATE: acc_next = acc_reg + prod_reg + data_reg;
            xsa_pkg::KIND_SCRAMBLE:   acc_next = prod_reg + {phi_reg, 32'b0};
            xsa_pkg::KIND_LOAD_ACC:   acc_next = data_reg;
            default:                  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/xxh3_stripe_accumulator_top.sv @@
// Channel  Direction  Signals                    Contents
// s_*      in         s_tvalid s_tready          tuser: kind; tdata: offset, lane words
// m_*      out        m_tvalid m_tready          tdata: accumulators 0..7
// cfg_*    in         cfg_valid cfg_ready        cfg_data: scramble multiplier
//
// One item per cycle for secret loads, stripes and accumulator loads while m_tready does
// not hold the output; a scramble holds the execute stage for its 32x32 multiplies on the
// live accumulators and then for the partial-product add. Each item passes the input
// stage, then the execute stage, before its result shows in the accumulators.
// Reset clears the accumulators and sets the multiplier to 0x9E3779B1; the secret
// store is undefined until written and gets no clearing pass.
// With m_tready low the result holds and two further items are absorbed.
module xxh3_stripe_accumulator_top #(
    parameter int SECRET_WORDS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] kind
    input  logic [xsa_pkg::KIND_W-1:0]         s_tuser,
    // [4:0] secret_offset, then lane_word_0 .. lane_word_7, zero fill on top
    input  logic [xsa_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // acc_out_0 .. acc_out_7, 64 bits each
    output logic [xsa_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xsa_pkg::MULT_W-1:0]         cfg_data
);

    logic                         accept;
    logic                         s1_move;
    logic                         s2_open;
    logic                         commit;
    logic                         mul_en;
    logic                         slot_free;

    logic                         s1_valid_reg, s1_valid_next;
    xsa_pkg::kind_t               s1_kind_reg;
    xsa_pkg::lane_words_t         s1_word_reg;
    logic                         s2_valid_reg, s2_valid_next;
    xsa_pkg::kind_t               s2_kind_reg;
    logic                         scr_phase_reg, scr_phase_next;
    logic                         out_valid_reg, out_valid_next;
    logic [xsa_pkg::MULT_W-1:0]   mult_reg;

    xsa_pkg::lane_words_t         in_words;
    xsa_pkg::lane_words_t         secret;
    xsa_pkg::lane_words_t         acc;
    xsa_pkg::lane_ctrl_t          lane_ctrl;

    always_comb
    begin
        for (int i = 0; i < xsa_pkg::LANES; i++)
        begin
            in_words[i] = s_tdata[xsa_pkg::OFFSET_W + i * xsa_pkg::WORD_W +: xsa_pkg::WORD_W];
        end
    end

    // Execute stage: a scramble multiplies first, then commits.
    assign slot_free = !out_valid_reg || m_tready;
    assign mul_en    = s2_valid_reg && (s2_kind_reg == xsa_pkg::KIND_SCRAMBLE) && !scr_phase_reg;
    assign commit    = s2_valid_reg && slot_free
                       && ((s2_kind_reg != xsa_pkg::KIND_SCRAMBLE) || scr_phase_reg);
    assign s2_open   = !s2_valid_reg || commit;
    assign s1_move   = s1_valid_reg && s2_open;
    assign s_tready  = !s1_valid_reg || s1_move;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !s1_move);
        s2_valid_next  = s1_move || (s2_valid_reg && !commit);
        out_valid_next = commit || (out_valid_reg && !m_tready);
        if (mul_en)
        begin
            scr_phase_next = 1'b1;
        end
        else if (commit)
        begin
            scr_phase_next = 1'b0;
        end
        else
        begin
            scr_phase_next = scr_phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            scr_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mult_reg      <= xsa_pkg::MULT_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            scr_phase_reg <= scr_phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                mult_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= s_tuser;
            s1_word_reg <= in_words;
        end
        if (s1_move)
        begin
            s2_kind_reg <= s1_kind_reg;
        end
    end

    xsa_secret_store #(
        .SECRET_WORDS(SECRET_WORDS)
    ) u_store (
        .clk    (clk),
        .rd_en  (accept),
        .wr_en  (accept && (s_tuser == xsa_pkg::KIND_LOAD_SECRET)),
        .offset (s_tdata[xsa_pkg::OFFSET_W-1:0]),
        .words  (in_words),
        .secret (secret)
    );

    always_comb
    begin
        lane_ctrl.load      = s1_move;
        lane_ctrl.load_kind = s1_kind_reg;
        lane_ctrl.mul_en    = mul_en;
        lane_ctrl.commit    = commit;
        lane_ctrl.op        = s2_kind_reg;
    end

    for (genvar i = 0; i < xsa_pkg::LANES; i++)
    begin : g_lane
        xsa_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (lane_ctrl),
            .word    (s1_word_reg[i]),
            .nb_word (s1_word_reg[i ^ 1]),
            .secret  (secret[i]),
            .mult    (mult_reg),
            .acc     (acc[i])
        );
    end

    assign m_tdata   = acc;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

    a_phase_in_scramble : assert property (@(posedge clk) disable iff (!rst_n)
        scr_phase_reg |-> (s2_valid_reg && (s2_kind_reg == xsa_pkg::KIND_SCRAMBLE)))
        else $error("scramble phase set without a scramble in execute");

    a_scramble_advances : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_kind_reg == xsa_pkg::KIND_SCRAMBLE) && !scr_phase_reg)
        |=> scr_phase_reg)
        else $error("scramble multiply did not advance");

    a_secret_load_keeps_acc : assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (s2_kind_reg == xsa_pkg::KIND_LOAD_SECRET))
        |=> (m_tdata == $past(m_tdata)))
        else $error("secret load changed the accumulators");

endmodule
